[hw/rtl/qmpp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package qmpp_pkg;

    // Build-time sizes.
    localparam int COORD_BITS     = 10;
    localparam int MAX_ITERATIONS = 63;
    localparam int CORDIC_STEPS   = 16;

    localparam int FRAC_BITS      = 26;
    localparam int ATAN_TABLE_LEN = 30;
    localparam int ATAN_IDX_W     = $clog2(ATAN_TABLE_LEN);
    localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);
    localparam int STEP_W         = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    // CORDIC datapath width: 32-bit z plus sign, negation and gain headroom.
    localparam int CORDIC_W       = 36;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MIN           = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX           = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_COUNT = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [31:0] X_MIN_RESET           = 32'hF400_0000;
    localparam logic [31:0] Y_MAX_RESET           = 32'h0800_0000;
    localparam logic [30:0] STEP_X_RESET          = 31'd268435;
    localparam logic [30:0] STEP_Y_RESET          = 31'd268435;
    localparam logic [5:0]  ITERATION_COUNT_RESET = 6'd10;

    // Angles are fractions of a turn, 2^32 being one full turn.
    localparam logic [31:0] TURN_ZERO    = 32'h0000_0000;
    localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
    localparam logic [31:0] TURN_HALF    = 32'h8000_0000;
    localparam logic [31:0] TURN_3QUART  = 32'hC000_0000;

    typedef struct packed {
        logic signed [31:0] x_min;
        logic signed [31:0] y_max;
        logic [30:0]        step_x;
        logic [30:0]        step_y;
        logic [5:0]         iteration_count;
    } cfg_t;

    typedef struct packed {
        logic [7:0] gray;
        logic       overflow;
    } result_t;

    // floor(atan(2^-i) / (2*pi) * 2^32)
    function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] val;
        begin
            case (idx)
                5'd0:    val = 32'h2000_0000;
                5'd1:    val = 32'h12E4_051D;
                5'd2:    val = 32'h09FB_385B;
                5'd3:    val = 32'h0511_11D4;
                5'd4:    val = 32'h028B_0D43;
                5'd5:    val = 32'h0145_D7E1;
                5'd6:    val = 32'h00A2_F61E;
                5'd7:    val = 32'h0051_7C55;
                5'd8:    val = 32'h0028_BE53;
                5'd9:    val = 32'h0014_5F2E;
                5'd10:   val = 32'h000A_2F98;
                5'd11:   val = 32'h0005_17CC;
                5'd12:   val = 32'h0002_8BE6;
                5'd13:   val = 32'h0001_45F3;
                5'd14:   val = 32'h0000_A2F9;
                5'd15:   val = 32'h0000_517C;
                5'd16:   val = 32'h0000_28BE;
                5'd17:   val = 32'h0000_145F;
                5'd18:   val = 32'h0000_0A2F;
                5'd19:   val = 32'h0000_0517;
                5'd20:   val = 32'h0000_028B;
                5'd21:   val = 32'h0000_0145;
                5'd22:   val = 32'h0000_00A2;
                5'd23:   val = 32'h0000_0051;
                5'd24:   val = 32'h0000_0028;
                5'd25:   val = 32'h0000_0014;
                5'd26:   val = 32'h0000_000A;
                5'd27:   val = 32'h0000_0005;
                5'd28:   val = 32'h0000_0002;
                5'd29:   val = 32'h0000_0001;
                default: val = 32'h0000_0000;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

[hw/rtl/qmpp_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

module qmpp_engine (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [9:0]                          px,
    input  wire logic [9:0]                          py,
    input  wire qmpp_pkg::cfg_t                      cfg,
    input  wire logic                                ack,
    output      logic                                idle,
    output      logic                                done,
    output      qmpp_pkg::result_t                   result
);

    localparam int CW = qmpp_pkg::CORDIC_W;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_CX   = 12'b0000_0000_0010,
        S_CY   = 12'b0000_0000_0100,
        S_CC   = 12'b0000_0000_1000,
        S_RR   = 12'b0000_0001_0000,
        S_II   = 12'b0000_0010_0000,
        S_RI   = 12'b0000_0100_0000,
        S_UPD  = 12'b0000_1000_0000,
        S_ANG  = 12'b0001_0000_0000,
        S_ROT  = 12'b0010_0000_0000,
        S_GRAY = 12'b0100_0000_0000,
        S_FIN  = 12'b1000_0000_0000
    } state_t;

    function automatic logic fits32(input logic signed [63:0] v);
        return (v[63:31] == '0) || (v[63:31] == '1);
    endfunction

    state_t                                  state_reg, state_next;
    logic [qmpp_pkg::COORD_BITS-1:0]         px_reg, px_next;
    logic [qmpp_pkg::COORD_BITS-1:0]         py_reg, py_next;
    logic signed [31:0]                      cr_reg, cr_next;
    logic signed [31:0]                      ci_reg, ci_next;
    logic signed [31:0]                      zr_reg, zr_next;
    logic signed [31:0]                      zi_reg, zi_next;
    logic signed [63:0]                      prod_reg, prod_next;
    logic signed [63:0]                      acc_reg, acc_next;
    logic [qmpp_pkg::ITER_W-1:0]             count_reg, count_next;
    logic [qmpp_pkg::STEP_W-1:0]             step_reg, step_next;
    logic signed [CW-1:0]                    x_reg, x_next;
    logic signed [CW-1:0]                    y_reg, y_next;
    logic [31:0]                             angle_reg, angle_next;
    qmpp_pkg::result_t                       res_reg, res_next;

    logic signed [31:0]                      mult_a;
    logic signed [31:0]                      mult_b;
    logic signed [63:0]                      cr_wide;
    logic signed [63:0]                      ci_wide;
    logic signed [63:0]                      cr_ext;
    logic signed [63:0]                      ci_ext;
    logic signed [63:0]                      nr_wide;
    logic signed [63:0]                      ni_wide;
    logic [qmpp_pkg::ITER_W-1:0]             iter_limit;
    logic [qmpp_pkg::ITER_W-1:0]             count_inc;
    logic signed [CW-1:0]                    dx;
    logic signed [CW-1:0]                    dy;
    logic [31:0]                             atan_val;
    logic [39:0]                             gray_wide;

    // Shared multiplier operand select.
    always_comb
    begin
        case (state_reg)
            S_CX:
            begin
                mult_a = $signed(32'(px_reg));
                mult_b = $signed({1'b0, cfg.step_x});
            end
            S_CY:
            begin
                mult_a = $signed(32'(py_reg));
                mult_b = $signed({1'b0, cfg.step_y});
            end
            S_RR:
            begin
                mult_a = zr_reg;
                mult_b = zr_reg;
            end
            S_II:
            begin
                mult_a = zi_reg;
                mult_b = zi_reg;
            end
            default:
            begin
                mult_a = zr_reg;
                mult_b = zi_reg;
            end
        endcase
    end

    assign prod_next = 64'(mult_a) * 64'(mult_b);

    assign cr_ext  = {{32{cr_reg[31]}}, cr_reg};
    assign ci_ext  = {{32{ci_reg[31]}}, ci_reg};
    assign cr_wide = {{32{cfg.x_min[31]}}, cfg.x_min} + prod_reg;
    assign ci_wide = {{32{cfg.y_max[31]}}, cfg.y_max} - prod_reg;
    assign nr_wide = (acc_reg >>> qmpp_pkg::FRAC_BITS) + cr_ext;
    assign ni_wide = (prod_reg >>> (qmpp_pkg::FRAC_BITS - 1)) + ci_ext;

    assign iter_limit = (32'(cfg.iteration_count) > qmpp_pkg::MAX_ITERATIONS)
                      ? qmpp_pkg::ITER_W'(qmpp_pkg::MAX_ITERATIONS)
                      : qmpp_pkg::ITER_W'(cfg.iteration_count);
    assign count_inc  = count_reg + qmpp_pkg::ITER_W'(1);

    assign dx        = y_reg >>> step_reg;
    assign dy        = x_reg >>> step_reg;
    assign atan_val  = qmpp_pkg::atan_turn(qmpp_pkg::ATAN_IDX_W'(step_reg));
    assign gray_wide = {angle_reg, 8'b0} - {8'b0, angle_reg};

    always_comb
    begin
        state_next = state_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        cr_next    = cr_reg;
        ci_next    = ci_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        acc_next   = acc_reg;
        count_next = count_reg;
        step_next  = step_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        angle_next = angle_reg;
        res_next   = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    px_next    = px[qmpp_pkg::COORD_BITS-1:0];
                    py_next    = py[qmpp_pkg::COORD_BITS-1:0];
                    state_next = S_CX;
                end
            end
            S_CX:
            begin
                state_next = S_CY;
            end
            S_CY:
            begin
                cr_next = cr_wide[31:0];
                if (!fits32(cr_wide))
                begin
                    res_next.gray     = 8'd0;
                    res_next.overflow = 1'b1;
                    state_next        = S_FIN;
                end
                else
                begin
                    state_next = S_CC;
                end
            end
            S_CC:
            begin
                ci_next    = ci_wide[31:0];
                zr_next    = cr_reg;
                zi_next    = ci_wide[31:0];
                count_next = '0;
                if (!fits32(ci_wide))
                begin
                    res_next.gray     = 8'd0;
                    res_next.overflow = 1'b1;
                    state_next        = S_FIN;
                end
                else if (iter_limit == '0)
                begin
                    state_next = S_ANG;
                end
                else
                begin
                    state_next = S_RR;
                end
            end
            S_RR:
            begin
                state_next = S_II;
            end
            S_II:
            begin
                acc_next   = prod_reg;
                state_next = S_RI;
            end
            S_RI:
            begin
                acc_next   = acc_reg - prod_reg;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                zr_next    = nr_wide[31:0];
                zi_next    = ni_wide[31:0];
                count_next = count_inc;
                if (!fits32(nr_wide) || !fits32(ni_wide))
                begin
                    res_next.gray     = 8'd0;
                    res_next.overflow = 1'b1;
                    state_next        = S_FIN;
                end
                else if (count_inc == iter_limit)
                begin
                    state_next = S_ANG;
                end
                else
                begin
                    state_next = S_RR;
                end
            end
            S_ANG:
            begin
                step_next = '0;
                if (zi_reg == '0)
                begin
                    angle_next = zr_reg[31] ? qmpp_pkg::TURN_HALF : qmpp_pkg::TURN_ZERO;
                    state_next = S_GRAY;
                end
                else if (zr_reg == '0)
                begin
                    angle_next = zi_reg[31] ? qmpp_pkg::TURN_3QUART : qmpp_pkg::TURN_QUARTER;
                    state_next = S_GRAY;
                end
                else
                begin
                    if (zr_reg[31])
                    begin
                        x_next     = -CW'(zr_reg);
                        y_next     = -CW'(zi_reg);
                        angle_next = qmpp_pkg::TURN_HALF;
                    end
                    else
                    begin
                        x_next     = CW'(zr_reg);
                        y_next     = CW'(zi_reg);
                        angle_next = qmpp_pkg::TURN_ZERO;
                    end
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                if (!y_reg[CW-1])
                begin
                    x_next     = x_reg + dx;
                    y_next     = y_reg - dy;
                    angle_next = angle_reg + atan_val;
                end
                else
                begin
                    x_next     = x_reg - dx;
                    y_next     = y_reg + dy;
                    angle_next = angle_reg - atan_val;
                end
                step_next = step_reg + qmpp_pkg::STEP_W'(1);
                if (step_reg == qmpp_pkg::STEP_W'(qmpp_pkg::CORDIC_STEPS - 1))
                begin
                    state_next = S_GRAY;
                end
            end
            S_GRAY:
            begin
                res_next.gray     = gray_wide[39:32];
                res_next.overflow = 1'b0;
                state_next        = S_FIN;
            end
            S_FIN:
            begin
                if (ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg    <= px_next;
        py_reg    <= py_next;
        cr_reg    <= cr_next;
        ci_reg    <= ci_next;
        zr_reg    <= zr_next;
        zi_reg    <= zi_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        angle_reg <= angle_next;
        res_reg   <= res_next;
    end

    assign idle   = (state_reg == S_IDLE);
    assign done   = (state_reg == S_FIN);
    assign result = res_reg;

endmodule

`default_nettype wire

[hw/rtl/quadratic_map_phase_pixel.sv]
`timescale 1ns / 1ps
`default_nettype none

// The sequencer forms c, runs the saturated iteration count of squaring rounds on the
// 32x32 multiplier and then takes the argument of the final z with the 16 CORDIC steps
// on the shift-add unit, which it skips when z lies on an axis; an overflow ends a pixel
// early. A new pixel is taken only after the previous one has left the sequencer.
// Reset (rst_n low, asynchronous) returns the sequencer to idle, empties the output
// register and loads the configuration registers with their default view window.

module quadratic_map_phase_pixel (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Pixel input channel.
    input  wire logic                              in_valid,
    output      logic                              in_ready,
    input  wire logic [9:0]                        pixel_x,
    input  wire logic [9:0]                        pixel_y,
    // Result channel.
    output      logic                              out_valid,
    input  wire logic                              out_ready,
    output      logic [7:0]                        gray,
    output      logic                              overflow,
    // Configuration write channel.
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [qmpp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [31:0]                       cfg_data
);

    qmpp_pkg::cfg_t     cfg_reg;
    qmpp_pkg::result_t  eng_result;
    logic               eng_idle;
    logic               eng_done;
    logic               out_take;
    logic               out_valid_reg;
    logic [7:0]         gray_reg;
    logic               overflow_reg;

    // Configuration registers. Writes are always taken; an index beyond the register list
    // is dropped. Software must only write with no pixel in flight; nothing enforces it.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_min           <= qmpp_pkg::X_MIN_RESET;
            cfg_reg.y_max           <= qmpp_pkg::Y_MAX_RESET;
            cfg_reg.step_x          <= qmpp_pkg::STEP_X_RESET;
            cfg_reg.step_y          <= qmpp_pkg::STEP_Y_RESET;
            cfg_reg.iteration_count <= qmpp_pkg::ITERATION_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                qmpp_pkg::CFG_X_MIN:           cfg_reg.x_min           <= cfg_data;
                qmpp_pkg::CFG_Y_MAX:           cfg_reg.y_max           <= cfg_data;
                qmpp_pkg::CFG_STEP_X:          cfg_reg.step_x          <= cfg_data[30:0];
                qmpp_pkg::CFG_STEP_Y:          cfg_reg.step_y          <= cfg_data[30:0];
                qmpp_pkg::CFG_ITERATION_COUNT: cfg_reg.iteration_count <= cfg_data[5:0];
                default:
                begin
                end
            endcase
        end
    end

    // The engine holds one pixel at a time. It takes a new word as soon as it
    // is back in idle, even while the previous result still sits in the
    // output register waiting for the consumer.
    assign in_ready = eng_idle;

    qmpp_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_valid && in_ready),
        .px     (pixel_x),
        .py     (pixel_y),
        .cfg    (cfg_reg),
        .ack    (out_take),
        .idle   (eng_idle),
        .done   (eng_done),
        .result (eng_result)
    );

    // Output register. A finished result moves in when the register is empty
    // or is being drained in the same cycle; otherwise the engine waits.
    assign out_take = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (eng_done && out_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_done && out_take)
        begin
            gray_reg     <= eng_result.gray;
            overflow_reg <= eng_result.overflow;
        end
    end

    assign out_valid = out_valid_reg;
    assign gray      = gray_reg;
    assign overflow  = overflow_reg;

endmodule

`default_nettype wire

[hw/rtl/qmpp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module qmpp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] gray,
    input wire logic       overflow
);

    // A stalled result word keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(gray) && $stable(overflow))
        else $error("result word changed while stalled");

    // An overflowed pixel always reports gray level zero.
    a_ovf_gray: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> gray == 8'd0)
        else $error("overflow word with nonzero gray");

    // Only one pixel is in flight: the input closes right after a word is taken.
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken twice in a row");

    // No result can appear in the cycle right after a pixel is taken.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result appeared too early");

endmodule

bind quadratic_map_phase_pixel qmpp_checker u_qmpp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .gray      (gray),
    .overflow  (overflow)
);

`default_nettype wire

[tb/sv/tb_quadratic_map_phase_pixel.sv]
`timescale 1ns / 1ps

module tb_quadratic_map_phase_pixel;
    import qmpp_pkg::*;

    // The watchdog allows many times the slowest pixel plus the longest sender
    // gap and receiver stall.
    localparam int WATCHDOG_LIMIT = 4000;
    // Quiet time after the last result, enough to cover a full-length pixel.
    localparam int SETTLE_CYCLES  = 4 * MAX_ITERATIONS + 40;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_WORDS    = 104;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    // Arctangent of 2^-i as a fraction of a turn, 2^32 being one full turn.
    localparam logic [31:0] ATAN_TURNS [0:29] = '{
        32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
        32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2E,
        32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9,
        32'h0000_517C, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
        32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051, 32'h0000_0028,
        32'h0000_0014, 32'h0000_000A, 32'h0000_0005, 32'h0000_0002, 32'h0000_0001
    };

    // The scoreboard keeps its own copy of the view window and iteration count,
    // predicts the gray level of every accepted pixel and holds the predictions
    // in order until the matching result word leaves the block.
    class shade_scoreboard;
        cfg_t    cfg;
        result_t shades_due[$];
        int      mismatches;

        function new();
            cfg.x_min           = X_MIN_RESET;
            cfg.y_max           = Y_MAX_RESET;
            cfg.step_x          = STEP_X_RESET;
            cfg.step_y          = STEP_Y_RESET;
            cfg.iteration_count = ITERATION_COUNT_RESET;
            mismatches          = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [31:0] data);
            case (index)
                CFG_X_MIN:           cfg.x_min = data;
                CFG_Y_MAX:           cfg.y_max = data;
                CFG_STEP_X:          cfg.step_x = data[30:0];
                CFG_STEP_Y:          cfg.step_y = data[30:0];
                CFG_ITERATION_COUNT: cfg.iteration_count = data[5:0];
                default:             ;
            endcase
        endfunction

        function bit fits_q(longint v);
            return (v >= Q_MIN) && (v <= Q_MAX);
        endfunction

        // Argument of (x, y) in turns. Points on an axis take the exact values,
        // all others go through the vectoring CORDIC with floor shifts.
        function logic [31:0] turn_angle(longint x, longint y);
            logic [31:0] angle;
            longint      dx;
            longint      dy;
            angle = TURN_ZERO;
            if (y == 0)
                return (x < 0) ? TURN_HALF : TURN_ZERO;
            if (x == 0)
                return (y > 0) ? TURN_QUARTER : TURN_3QUART;
            if (x < 0)
            begin
                x     = -x;
                y     = -y;
                angle = TURN_HALF;
            end
            for (int i = 0; i < CORDIC_STEPS && i < 30; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0)
                begin
                    x     = x + dx;
                    y     = y - dy;
                    angle = angle + ATAN_TURNS[i];
                end
                else
                begin
                    x     = x - dx;
                    y     = y + dy;
                    angle = angle - ATAN_TURNS[i];
                end
            end
            return angle;
        endfunction

        function result_t phase_shade(logic [9:0] px, logic [9:0] py);
            result_t     shade;
            longint      cr;
            longint      ci;
            longint      zr;
            longint      zi;
            longint      nr;
            longint      ni;
            int          rounds;
            logic [63:0] scaled;
            shade.gray     = 8'd0;
            shade.overflow = 1'b1;
            rounds = int'(cfg.iteration_count);
            if (rounds > MAX_ITERATIONS)
                rounds = MAX_ITERATIONS;
            cr = longint'($signed(cfg.x_min)) + longint'(px) * longint'(cfg.step_x);
            ci = longint'($signed(cfg.y_max)) - longint'(py) * longint'(cfg.step_y);
            if (!fits_q(cr) || !fits_q(ci))
                return shade;
            zr = cr;
            zi = ci;
            for (int k = 0; k < rounds; k++)
            begin
                nr = ((zr * zr - zi * zi) >>> FRAC_BITS) + cr;
                ni = ((zr * zi) >>> (FRAC_BITS - 1)) + ci;
                if (!fits_q(nr) || !fits_q(ni))
                    return shade;
                zr = nr;
                zi = ni;
            end
            scaled         = {32'd0, turn_angle(zr, zi)} * 64'd255;
            shade.gray     = scaled[39:32];
            shade.overflow = 1'b0;
            return shade;
        endfunction

        function void note_pixel(logic [9:0] px, logic [9:0] py);
            shades_due.push_back(phase_shade(px, py));
        endfunction

        function void check_shade(logic [7:0] got_gray, logic got_overflow);
            result_t want;
            if (shades_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result word with nothing pending: gray %0d overflow %b",
                             $realtime, got_gray, got_overflow);
                return;
            end
            want = shades_due.pop_front();
            if (got_gray !== want.gray || got_overflow !== want.overflow)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: gray %0d overflow %b, expected gray %0d overflow %b",
                             $realtime, got_gray, got_overflow, want.gray, want.overflow);
            end
        endfunction

        function int pending();
            return shades_due.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [9:0]           pixel_x;
    logic [9:0]           pixel_y;
    logic                 out_valid;
    logic                 out_ready;
    logic [7:0]           gray;
    logic                 overflow;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    // When low, neither side inserts gaps, so words go back to back.
    bit stalls_on;
    int out_stall_left;
    int quiet_cycles;

    shade_scoreboard sb = new();

    quadratic_map_phase_pixel dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .gray      (gray),
        .overflow  (overflow),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Monitor. Every handshake is sampled at the rising edge, so the values seen
    // are the ones that were settled just before it. Register writes update the
    // mirror, accepted pixels get a prediction and result words are checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_pixel(pixel_x, pixel_y);
            if (out_valid && out_ready)
                sb.check_shade(gray, overflow);
        end
    end

    // Receiver. After each accepted result it draws a stall length; the stall
    // only counts down while a result is actually waiting, so it always bites.
    always @(posedge clk)
    begin : receiver
        int stall;
        if (out_valid && out_ready)
        begin
            stall = stalls_on ? $urandom_range(10, 0) : 0;
            out_stall_left <= stall;
            out_ready      <= (stall == 0);
        end
        else if (!out_ready && out_valid)
        begin
            if (out_stall_left <= 1)
                out_ready <= 1'b1;
            out_stall_left <= out_stall_left - 1;
        end
    end

    // Watchdog: a long stretch without any word moving on any channel means
    // the block has hung.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("quadratic_map_phase_pixel verification failed");
            $finish;
        end
    end

    // Writes one register and lowers the valid for the cycle after it is taken,
    // so two writes in a row never touch cfg_valid twice in the same time step.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one pixel word after a random gap and returns at the edge where it
    // was taken. With no gap the valid simply stays high for the next word.
    task automatic send_pixel(input logic [9:0] px, input logic [9:0] py);
        int gap;
        gap = stalls_on ? $urandom_range(10, 0) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_x  <= px;
        pixel_y  <= py;
        do @(posedge clk); while (!in_ready);
    endtask

    // Holds the sender back until every predicted shade has come out. Every
    // pixel yields exactly one result, so the block is idle afterwards. The
    // first edge lets the monitor record the word accepted just before.
    task automatic wait_all_shades();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [31:0] xv;
        logic [31:0] yv;
        logic [31:0] sxv;
        logic [31:0] syv;
        logic [31:0] itv;
        logic [9:0]  px;
        logic [9:0]  py;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        pixel_x        = '0;
        pixel_y        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        out_ready      = 1'b1;
        out_stall_left = 0;
        quiet_cycles   = 0;
        stalls_on      = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default view window straight out of reset: the corners and the centre.
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd512, 10'd512);

        // Unit grid with -2 + 2i at the top left corner and no iterations, so
        // c itself is measured: the origin, all four half axes and two
        // diagonal points.
        wait_all_shades();
        write_cfg(CFG_X_MIN, 32'hF800_0000);
        write_cfg(CFG_Y_MAX, 32'h0800_0000);
        write_cfg(CFG_STEP_X, 32'h0400_0000);
        write_cfg(CFG_STEP_Y, 32'h0400_0000);
        write_cfg(CFG_ITERATION_COUNT, 32'd0);
        send_pixel(10'd2, 10'd2);
        send_pixel(10'd3, 10'd2);
        send_pixel(10'd0, 10'd2);
        send_pixel(10'd2, 10'd0);
        send_pixel(10'd2, 10'd4);
        send_pixel(10'd3, 10'd1);
        send_pixel(10'd1, 10'd3);

        // Same grid at the full iteration count: c = -1 ends on zero, c = -2
        // settles on the positive real axis, c = i alternates between -1 + i and -i,
        // and c = 2 or -1 + i escape and overflow.
        wait_all_shades();
        write_cfg(CFG_ITERATION_COUNT, 32'd63);
        send_pixel(10'd1, 10'd2);
        send_pixel(10'd0, 10'd2);
        send_pixel(10'd2, 10'd1);
        send_pixel(10'd4, 10'd2);
        send_pixel(10'd1, 10'd1);

        // Edge of the number range: c at the extreme corner still fits, one
        // step further overflows on either axis. The writes to unused indexes
        // must leave the window alone.
        wait_all_shades();
        write_cfg(CFG_X_MIN, 32'h7FFF_FFFF);
        write_cfg(CFG_Y_MAX, 32'h8000_0000);
        write_cfg(CFG_STEP_X, 32'hFFFF_FFFF);
        write_cfg(CFG_STEP_Y, 32'hFFFF_FFFF);
        write_cfg(CFG_ITERATION_COUNT, 32'hFFFF_FFC0);
        write_cfg(3'd5, 32'hFFFF_FFFF);
        write_cfg(3'd6, 32'h0000_0000);
        write_cfg(3'd7, 32'hA5A5_5A5A);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1, 10'd0);
        send_pixel(10'd0, 10'd1);
        send_pixel(10'd1023, 10'd1023);

        // Random phases. Most use a window over the interesting part of the
        // plane so that many pixels survive the iterations; one phase throws
        // fully random register values at the block and one mixes extremes.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_all_shades();
            stalls_on <= (phase % 3 != 1);
            case (phase)
                2:
                begin
                    xv  = $urandom;
                    yv  = $urandom;
                    sxv = $urandom;
                    syv = $urandom;
                    itv = $urandom;
                end
                5:
                begin
                    case ($urandom_range(2, 0))
                        0:       xv = 32'h8000_0000;
                        1:       xv = 32'h0000_0000;
                        default: xv = 32'h7FFF_FFFF;
                    endcase
                    case ($urandom_range(2, 0))
                        0:       yv = 32'h8000_0000;
                        1:       yv = 32'h0000_0000;
                        default: yv = 32'h7FFF_FFFF;
                    endcase
                    sxv = $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'd0;
                    syv = $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'd0;
                    itv = $urandom_range(1, 0) ? 32'd63 : 32'd0;
                end
                default:
                begin
                    // Real part from -2.5 to 0.5, top edge from 0 to 1.5, and
                    // steps that span up to about four units over the image.
                    xv  = 32'($urandom_range(201326592, 0)) - 32'd167772160;
                    yv  = $urandom_range(100663296, 0);
                    sxv = $urandom_range(262144, 0);
                    syv = $urandom_range(262144, 0);
                    itv = $urandom_range(63, 0);
                end
            endcase
            write_cfg(CFG_X_MIN, xv);
            write_cfg(CFG_Y_MAX, yv);
            write_cfg(CFG_STEP_X, sxv);
            write_cfg(CFG_STEP_Y, syv);
            write_cfg(CFG_ITERATION_COUNT, itv);
            write_cfg(3'($urandom_range(7, 5)), $urandom);

            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if ($urandom_range(7, 0) == 0)
                begin
                    px = $urandom_range(1, 0) ? 10'd1023 : 10'd0;
                    py = $urandom_range(1, 0) ? 10'd1023 : 10'd0;
                end
                else
                begin
                    px = 10'($urandom_range(1023, 0));
                    py = 10'($urandom_range(1023, 0));
                end
                send_pixel(px, py);
                // Now and then let the pipe run completely dry.
                if ($urandom_range(39, 0) == 0)
                    wait_all_shades();
            end
        end

        wait_all_shades();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("quadratic_map_phase_pixel verification clean");
        else
            $display("quadratic_map_phase_pixel verification failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/qmpp_pkg.sv
hw/rtl/qmpp_engine.sv
hw/rtl/quadratic_map_phase_pixel.sv
hw/rtl/qmpp_checker.sv
tb/sv/tb_quadratic_map_phase_pixel.sv
